[rtl/core/scalar_to_colour_map_assert.svh]
// Assertion macros shared by the scalar_to_colour_map RTL.
`ifndef SCALAR_TO_COLOUR_MAP_ASSERT_SVH
`define SCALAR_TO_COLOUR_MAP_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scalar_to_colour_map: assertion failed");

// Next-cycle implication, checked at every edge including reset.
`define ASSERT_AFTER(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scalar_to_colour_map: assertion failed");

`endif

[rtl/core/stcm_pkg.sv]
// Shared types and constants for the scalar-to-colour mapper.
package stcm_pkg;

  // Default number of fraction bits of the normalized sample.
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W    = 32;
  localparam int CHAN_W      = 8;
  localparam int PCT_W       = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Register reset values.
  localparam logic signed [SAMPLE_W-1:0] RANGE_MIN_RST = 32'sd0;
  localparam logic signed [SAMPLE_W-1:0] RANGE_MAX_RST = 32'sd255;
  localparam logic [PCT_W-1:0]           SAT_RST       = 7'd60;
  localparam logic [PCT_W-1:0]           BRIGHT_RST    = 7'd100;

  // Colour modes; the unused code behaves as greyscale.
  typedef enum logic [1:0] {
    MODE_GREY    = 2'd0,
    MODE_RAINBOW = 2'd1,
    MODE_TEMP    = 2'd2
  } colour_mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOUR_MODE = 3'd0,
    REG_RANGE_MIN   = 3'd1,
    REG_RANGE_MAX   = 3'd2,
    REG_SATURATION  = 3'd3,
    REG_BRIGHTNESS  = 3'd4
  } reg_index_t;

  // How the normalized fraction is formed after the divider.
  typedef enum logic [1:0] {
    XSEL_DIV  = 2'd0,
    XSEL_ZERO = 2'd1,
    XSEL_ONE  = 2'd2
  } xsel_t;

  // Control values derived from configuration for the colour stages.
  typedef struct packed {
    colour_mode_t        mode;
    logic                sat_zero;
    logic [CHAN_W-1:0]   sat_grey;
  } cfg_ctrl_t;

endpackage

[rtl/core/stcm_regs.sv]
// Configuration registers and the fixed-point HSV constants derived from them.
module stcm_regs #(
  parameter int FRAC_BITS = stcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [stcm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [stcm_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic signed [stcm_pkg::SAMPLE_W-1:0]   range_min,
  output logic signed [stcm_pkg::SAMPLE_W-1:0]   range_max,
  output stcm_pkg::cfg_ctrl_t                    ctrl,
  output logic [FRAC_BITS:0]                     sat_fx,
  output logic [FRAC_BITS:0]                     val_fx,
  output logic [FRAC_BITS:0]                     p_fx
);

  localparam int W  = FRAC_BITS + 1;
  localparam int N  = FRAC_BITS + stcm_pkg::PCT_W;  // width of percent << FRAC_BITS
  localparam int K  = N + 7;                         // reciprocal shift for divide by 100
  localparam int M  = K - 6;                         // reciprocal width
  localparam int PW = N + M;
  localparam logic [63:0]  RECIP64 = ((64'd1 << K) + 64'd99) / 64'd100;
  localparam logic [M-1:0] RECIP   = RECIP64[M-1:0];
  localparam logic [W-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};

  stcm_pkg::colour_mode_t              mode_r;
  logic signed [stcm_pkg::SAMPLE_W-1:0] min_r;
  logic signed [stcm_pkg::SAMPLE_W-1:0] max_r;
  logic [stcm_pkg::PCT_W-1:0]          sat_r;
  logic [stcm_pkg::PCT_W-1:0]          bri_r;

  logic [stcm_pkg::PCT_W-1:0] sat_clip_r;
  logic [stcm_pkg::PCT_W-1:0] bri_clip_r;
  logic [PW-1:0]              sat_prod_r;
  logic [PW-1:0]              bri_prod_r;
  logic [W-1:0]               s_r;
  logic [W-1:0]               v_r;
  logic [W-1:0]               p_r;
  logic                       sat_zero_r;
  logic [stcm_pkg::CHAN_W-1:0] grey_r;

  logic [PW-1:0]  sat_prod_nxt;
  logic [PW-1:0]  bri_prod_nxt;
  logic [2*W-1:0] p_prod;
  logic [8:0]     grey9;

  // The write channel never stalls.
  assign cfg_ready = 1'b1;

  // Register writes; data is trimmed to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stcm_pkg::MODE_GREY;
      min_r  <= stcm_pkg::RANGE_MIN_RST;
      max_r  <= stcm_pkg::RANGE_MAX_RST;
      sat_r  <= stcm_pkg::SAT_RST;
      bri_r  <= stcm_pkg::BRIGHT_RST;
    end else if (cfg_valid) begin
      case (stcm_pkg::reg_index_t'(cfg_index))
        stcm_pkg::REG_COLOUR_MODE: mode_r <= stcm_pkg::colour_mode_t'(cfg_data[1:0]);
        stcm_pkg::REG_RANGE_MIN:   min_r  <= $signed(cfg_data[stcm_pkg::SAMPLE_W-1:0]);
        stcm_pkg::REG_RANGE_MAX:   max_r  <= $signed(cfg_data[stcm_pkg::SAMPLE_W-1:0]);
        stcm_pkg::REG_SATURATION:  sat_r  <= cfg_data[stcm_pkg::PCT_W-1:0];
        stcm_pkg::REG_BRIGHTNESS:  bri_r  <= cfg_data[stcm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Percent to fixed point: floor(pct * 2^F / 100) by reciprocal multiply.
  assign sat_prod_nxt = PW'({sat_clip_r, {FRAC_BITS{1'b0}}}) * PW'(RECIP);
  assign bri_prod_nxt = PW'({bri_clip_r, {FRAC_BITS{1'b0}}}) * PW'(RECIP);

  // Rainbow p term and the grey level used when saturation is zero.
  assign p_prod = (2*W)'(v_r) * (2*W)'(ONE - s_r);
  assign grey9  = v_r[FRAC_BITS -: 9];

  // Free-running derivation pipeline; it settles long before an item needs it.
  always_ff @(posedge clk) begin
    sat_clip_r <= (sat_r > stcm_pkg::PCT_MAX) ? stcm_pkg::PCT_MAX : sat_r;
    bri_clip_r <= (bri_r > stcm_pkg::PCT_MAX) ? stcm_pkg::PCT_MAX : bri_r;
    sat_prod_r <= sat_prod_nxt;
    bri_prod_r <= bri_prod_nxt;
    s_r        <= sat_prod_r[K +: W];
    v_r        <= bri_prod_r[K +: W];
    p_r        <= p_prod[FRAC_BITS +: W];
    sat_zero_r <= (s_r == '0);
    grey_r     <= grey9[8] ? 8'hFF : grey9[7:0];
  end

  assign range_min     = min_r;
  assign range_max     = max_r;
  assign ctrl.mode     = mode_r;
  assign ctrl.sat_zero = sat_zero_r;
  assign ctrl.sat_grey = grey_r;
  assign sat_fx        = s_r;
  assign val_fx        = v_r;
  assign p_fx          = p_r;

endmodule

[rtl/core/stcm_norm.sv]
// Front end: sample offset, range width and the special-case decision.
module stcm_norm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [stcm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [stcm_pkg::SAMPLE_W-1:0] range_min,
  input  logic signed [stcm_pkg::SAMPLE_W-1:0] range_max,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [stcm_pkg::SAMPLE_W-1:0]        out_rem,
  output stcm_pkg::xsel_t                      out_sel,
  output logic [stcm_pkg::SAMPLE_W-1:0]        den
);

  localparam int DW = stcm_pkg::SAMPLE_W + 1;

  logic                vld_a_r;
  logic [DW-1:0]       diff_r;
  logic [DW-1:0]       den_r;
  logic                vld_b_r;
  logic [stcm_pkg::SAMPLE_W-1:0] rem_r;
  stcm_pkg::xsel_t     sel_r;

  logic en_a;
  logic en_b;
  logic empty;
  logic num_le0;
  logic num_ge;
  stcm_pkg::xsel_t sel_nxt;

  // Each stage moves when it is empty or the next one moves.
  assign en_b     = !vld_b_r || out_ready;
  assign en_a     = !vld_a_r || en_b;
  assign in_ready = en_a;

  // Range width follows the registers every cycle.
  always_ff @(posedge clk) begin
    den_r <= {range_max[stcm_pkg::SAMPLE_W-1], range_max}
           - {range_min[stcm_pkg::SAMPLE_W-1], range_min};
  end

  // Stage A: offset of the sample from the bottom of the range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en_a) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      diff_r <= {sample[stcm_pkg::SAMPLE_W-1], sample}
              - {range_min[stcm_pkg::SAMPLE_W-1], range_min};
    end
  end

  // Empty range, below range and above range bypass the divider.
  assign empty   = den_r[DW-1] || (den_r == '0);
  assign num_le0 = diff_r[DW-1] || (diff_r == '0);
  assign num_ge  = !diff_r[DW-1]
                && (diff_r[stcm_pkg::SAMPLE_W-1:0] >= den_r[stcm_pkg::SAMPLE_W-1:0]);

  always_comb begin
    if (empty || num_le0) begin
      sel_nxt = stcm_pkg::XSEL_ZERO;
    end else if (num_ge) begin
      sel_nxt = stcm_pkg::XSEL_ONE;
    end else begin
      sel_nxt = stcm_pkg::XSEL_DIV;
    end
  end

  // Stage B: dividend and bypass select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en_b) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      sel_r <= sel_nxt;
      rem_r <= (sel_nxt == stcm_pkg::XSEL_DIV) ? diff_r[stcm_pkg::SAMPLE_W-1:0] : '0;
    end
  end

  assign out_valid = vld_b_r;
  assign out_rem   = rem_r;
  assign out_sel   = sel_r;
  assign den       = den_r[stcm_pkg::SAMPLE_W-1:0];

endmodule

[rtl/core/stcm_div_stage.sv]
// One restoring-division step: yields one quotient bit per pipeline stage.
module stcm_div_stage #(
  parameter int FRAC_BITS = stcm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stcm_pkg::SAMPLE_W-1:0] in_rem,
  input  logic [FRAC_BITS-1:0]          in_q,
  input  stcm_pkg::xsel_t               in_sel,
  input  logic [stcm_pkg::SAMPLE_W-1:0] den,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stcm_pkg::SAMPLE_W-1:0] out_rem,
  output logic [FRAC_BITS-1:0]          out_q,
  output stcm_pkg::xsel_t               out_sel
);

  localparam int RW = stcm_pkg::SAMPLE_W;

  logic          vld_r;
  logic [RW-1:0] rem_r;
  logic [FRAC_BITS-1:0] q_r;
  stcm_pkg::xsel_t sel_r;

  logic          en;
  logic [RW:0]   rem2;
  logic [RW+1:0] trial;
  logic          ge;

  assign en       = !vld_r || out_ready;
  assign in_ready = en;

  // Shift in a zero and try to subtract the divisor.
  assign rem2  = {in_rem, 1'b0};
  assign trial = {1'b0, rem2} - {2'b00, den};
  assign ge    = !trial[RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? trial[RW-1:0] : rem2[RW-1:0];
      q_r   <= {in_q[FRAC_BITS-2:0], ge};
      sel_r <= in_sel;
    end
  end

  assign out_valid = vld_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;
  assign out_sel   = sel_r;

endmodule

[rtl/core/stcm_colour.sv]
// Colour back end: greyscale, six-sector HSV rainbow and temperature ramp.
`include "scalar_to_colour_map_assert.svh"

module stcm_colour #(
  parameter int FRAC_BITS = stcm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FRAC_BITS-1:0]        in_q,
  input  stcm_pkg::xsel_t             in_sel,
  input  stcm_pkg::cfg_ctrl_t         ctrl,
  input  logic [FRAC_BITS:0]          sat_fx,
  input  logic [FRAC_BITS:0]          val_fx,
  input  logic [FRAC_BITS:0]          p_fx,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [stcm_pkg::CHAN_W-1:0] red,
  output logic [stcm_pkg::CHAN_W-1:0] green,
  output logic [stcm_pkg::CHAN_W-1:0] blue
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W+1:0]   ONE_E   = (W+2)'(ONE);
  localparam logic [W+1:0]   TWO_E   = ONE_E << 1;

  // Channel byte: floor(255 * c / 2^F), never above 255 for c <= 1.0.
  function automatic logic [stcm_pkg::CHAN_W-1:0] to8(input logic [W-1:0] c);
    logic [W+7:0] m;
    m = {c, 8'b0} - {8'b0, c};
    return m[FRAC_BITS +: 8];
  endfunction

  // Stage 1 registers.
  logic         vld1_r;
  logic [W-1:0] x1_r;
  logic [2:0]   sec1_r;
  logic [FRAC_BITS-1:0] f1_r;
  logic [W+1:0] t31_r;
  // Stage 2 registers.
  logic         vld2_r;
  logic [W-1:0] x2_r, sf2_r, sfc2_r, tr2_r, tg2_r, tb2_r;
  logic [2:0]   sec2_r;
  // Stage 3 registers.
  logic         vld3_r;
  logic [W-1:0] x3_r, q3_r, t3_r, tr3_r, tg3_r, tb3_r;
  logic [2:0]   sec3_r;
  // Stage 4 registers.
  logic         vld4_r;
  logic [W-1:0] cr4_r, cg4_r, cb4_r;
  logic         use_grey4_r;
  logic [stcm_pkg::CHAN_W-1:0] grey4_r;
  stcm_pkg::colour_mode_t      kind4_r;
  // Output registers.
  logic         vld5_r;
  logic [stcm_pkg::CHAN_W-1:0] red_r, green_r, blue_r;
  stcm_pkg::colour_mode_t      kind5_r;

  logic en1, en2, en3, en4, en5;
  logic [W-1:0]   x;
  logic [W+2:0]   h6;
  logic [2:0]     sec_raw;
  logic [2:0]     sec_nxt;
  logic [FRAC_BITS-1:0] f_nxt;
  logic [W-1:0]   f_comp;
  logic [W+FRAC_BITS-1:0] sf_prod;
  logic [2*W-1:0] sfc_prod;
  logic [W-1:0]   tr_nxt, tg_nxt, tb_nxt;
  logic [2*W-1:0] q_prod, t_prod;
  logic [W-1:0]   cr_nxt, cg_nxt, cb_nxt;
  logic           use_grey_nxt;
  stcm_pkg::colour_mode_t kind_nxt;

  // Stall chain: a stage moves when empty or when the next stage moves.
  assign en5      = !vld5_r || out_ready;
  assign en4      = !vld4_r || en5;
  assign en3      = !vld3_r || en4;
  assign en2      = !vld2_r || en3;
  assign en1      = !vld1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
    end
  end

  // Stage 1: fraction, hue sector and offset, temperature position.
  always_comb begin
    case (in_sel)
      stcm_pkg::XSEL_ONE:  x = ONE;
      stcm_pkg::XSEL_ZERO: x = '0;
      default:             x = {1'b0, in_q};
    endcase
  end

  assign h6      = (W+3)'({x, 2'b00}) + (W+3)'({x, 1'b0});
  assign sec_raw = h6[FRAC_BITS +: 3];

  // Full hue wraps to the first sector.
  always_comb begin
    if (sec_raw >= 3'd6) begin
      sec_nxt = 3'd0;
      f_nxt   = '0;
    end else begin
      sec_nxt = sec_raw;
      f_nxt   = h6[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r   <= x;
      sec1_r <= sec_nxt;
      f1_r   <= f_nxt;
      t31_r  <= (W+2)'({x, 1'b0}) + (W+2)'(x);
    end
  end

  // Stage 2: saturation products and temperature channel fractions.
  assign f_comp   = ONE - W'(f1_r);
  assign sf_prod  = (W+FRAC_BITS)'(sat_fx) * (W+FRAC_BITS)'(f1_r);
  assign sfc_prod = (2*W)'(sat_fx) * (2*W)'(f_comp);

  always_comb begin
    tr_nxt = (t31_r < ONE_E) ? t31_r[W-1:0] : ONE;
    if (t31_r <= ONE_E) begin
      tg_nxt = '0;
    end else if (t31_r < TWO_E) begin
      tg_nxt = W'(t31_r - ONE_E);
    end else begin
      tg_nxt = ONE;
    end
    tb_nxt = (t31_r < TWO_E) ? '0 : W'(t31_r - TWO_E);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      x2_r   <= x1_r;
      sec2_r <= sec1_r;
      sf2_r  <= sf_prod[FRAC_BITS +: W];
      sfc2_r <= sfc_prod[FRAC_BITS +: W];
      tr2_r  <= tr_nxt;
      tg2_r  <= tg_nxt;
      tb2_r  <= tb_nxt;
    end
  end

  // Stage 3: value products for the q and t terms.
  assign q_prod = (2*W)'(val_fx) * (2*W)'(ONE - sf2_r);
  assign t_prod = (2*W)'(val_fx) * (2*W)'(ONE - sfc2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      x3_r   <= x2_r;
      sec3_r <= sec2_r;
      q3_r   <= q_prod[FRAC_BITS +: W];
      t3_r   <= t_prod[FRAC_BITS +: W];
      tr3_r  <= tr2_r;
      tg3_r  <= tg2_r;
      tb3_r  <= tb2_r;
    end
  end

  // Stage 4: pick the channel fractions for the active mode.
  always_comb begin
    cr_nxt       = x3_r;
    cg_nxt       = x3_r;
    cb_nxt       = x3_r;
    use_grey_nxt = 1'b0;
    kind_nxt     = stcm_pkg::MODE_GREY;
    case (ctrl.mode)
      stcm_pkg::MODE_RAINBOW: begin
        kind_nxt     = stcm_pkg::MODE_RAINBOW;
        use_grey_nxt = ctrl.sat_zero;
        case (sec3_r)
          3'd0: begin cr_nxt = val_fx; cg_nxt = t3_r;   cb_nxt = p_fx;   end
          3'd1: begin cr_nxt = q3_r;   cg_nxt = val_fx; cb_nxt = p_fx;   end
          3'd2: begin cr_nxt = p_fx;   cg_nxt = val_fx; cb_nxt = t3_r;   end
          3'd3: begin cr_nxt = p_fx;   cg_nxt = q3_r;   cb_nxt = val_fx; end
          3'd4: begin cr_nxt = t3_r;   cg_nxt = p_fx;   cb_nxt = val_fx; end
          default: begin cr_nxt = val_fx; cg_nxt = p_fx; cb_nxt = q3_r;  end
        endcase
      end
      stcm_pkg::MODE_TEMP: begin
        kind_nxt = stcm_pkg::MODE_TEMP;
        cr_nxt   = tr3_r;
        cg_nxt   = tg3_r;
        cb_nxt   = tb3_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      cr4_r       <= cr_nxt;
      cg4_r       <= cg_nxt;
      cb4_r       <= cb_nxt;
      use_grey4_r <= use_grey_nxt;
      grey4_r     <= ctrl.sat_grey;
      kind4_r     <= kind_nxt;
    end
  end

  // Stage 5: scale to bytes into the output register.
  always_ff @(posedge clk) begin
    if (en5) begin
      red_r   <= use_grey4_r ? grey4_r : to8(cr4_r);
      green_r <= use_grey4_r ? grey4_r : to8(cg4_r);
      blue_r  <= use_grey4_r ? grey4_r : to8(cb4_r);
      kind5_r <= kind4_r;
    end
  end

  assign out_valid = vld5_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  // Greyscale results carry one level on all channels.
  `ASSERT_IMPLIES(a_grey_equal, vld5_r && kind5_r == stcm_pkg::MODE_GREY, red_r == green_r && green_r == blue_r)
  // The temperature ramp never lets a later channel pass an earlier one.
  `ASSERT_IMPLIES(a_temp_order, vld5_r && kind5_r == stcm_pkg::MODE_TEMP, red_r >= green_r && green_r >= blue_r)

endmodule

[rtl/core/scalar_to_colour_map.sv]
// Top level of the scalar-to-colour mapper: registers, normalizer, divider, colour stages.
//
// Usage:
//   in_*  stream: one signed 32-bit sample per transfer on in_tdata.
//   out_* stream: one RGB colour per sample, red in the low byte of out_tdata.
//   cfg_* channel: register writes (index 0 mode, 1 range min, 2 range max,
//     3 saturation percent, 4 brightness percent); cfg_ready is always high.
//     Write only while no sample is in flight.
// Pipeline: two front-end stages, one restoring-division stage per fraction bit
//   and five colour stages. Throughput: one sample per cycle while out_tready
//   is high.
// Stalls: each stage holds its data while the stage after it is full and stalled, so
//   empty slots fill while out_tready is low; in_tready drops only once
//   every stage is occupied. Nothing is dropped or repeated.
// Reset: synchronous rst_n clears all valid bits and restores the register
//   defaults (greyscale, range 0..255, saturation 60%, brightness 100%).
//   Derived HSV constants settle through the clip, product, fraction and p/grey registers after any register write.
`include "scalar_to_colour_map_assert.svh"

module scalar_to_colour_map #(
  parameter int FRAC_BITS = stcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // [31:0] sample
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic signed [stcm_pkg::SAMPLE_W-1:0] range_min;
  logic signed [stcm_pkg::SAMPLE_W-1:0] range_max;
  stcm_pkg::cfg_ctrl_t                  ctrl;
  logic [FRAC_BITS:0]                   sat_fx;
  logic [FRAC_BITS:0]                   val_fx;
  logic [FRAC_BITS:0]                   p_fx;
  logic [stcm_pkg::SAMPLE_W-1:0]        den;

  // Divider chain links; index 0 is the front end, index FRAC_BITS the last step.
  logic [stcm_pkg::SAMPLE_W-1:0] rem_w [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]          q_w   [0:FRAC_BITS];
  stcm_pkg::xsel_t               sel_w [0:FRAC_BITS];
  logic [FRAC_BITS:0]            vld_w;
  logic [FRAC_BITS:0]            rdy_w;

  logic [stcm_pkg::CHAN_W-1:0] red;
  logic [stcm_pkg::CHAN_W-1:0] green;
  logic [stcm_pkg::CHAN_W-1:0] blue;

  // Configuration registers and derived constants.
  stcm_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .range_min (range_min),
    .range_max (range_max),
    .ctrl      (ctrl),
    .sat_fx    (sat_fx),
    .val_fx    (val_fx),
    .p_fx      (p_fx)
  );

  // Offset, range width and bypass decision.
  stcm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sample    ($signed(in_tdata[stcm_pkg::SAMPLE_W-1:0])),
    .range_min (range_min),
    .range_max (range_max),
    .out_valid (vld_w[0]),
    .out_ready (rdy_w[0]),
    .out_rem   (rem_w[0]),
    .out_sel   (sel_w[0]),
    .den       (den)
  );

  assign q_w[0] = '0;

  // One quotient bit per stage.
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
    stcm_div_stage #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_w[g]),
      .in_ready  (rdy_w[g]),
      .in_rem    (rem_w[g]),
      .in_q      (q_w[g]),
      .in_sel    (sel_w[g]),
      .den       (den),
      .out_valid (vld_w[g+1]),
      .out_ready (rdy_w[g+1]),
      .out_rem   (rem_w[g+1]),
      .out_q     (q_w[g+1]),
      .out_sel   (sel_w[g+1])
    );
  end

  // Colour mapping and output register.
  stcm_colour #(
    .FRAC_BITS (FRAC_BITS)
  ) u_colour (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_w[FRAC_BITS]),
    .in_ready  (rdy_w[FRAC_BITS]),
    .in_q      (q_w[FRAC_BITS]),
    .in_sel    (sel_w[FRAC_BITS]),
    .ctrl      (ctrl),
    .sat_fx    (sat_fx),
    .val_fx    (val_fx),
    .p_fx      (p_fx),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

  // Input backpressure only appears when the whole pipeline is full and stalled.
  `ASSERT_IMPLIES(a_stall_only_when_full, !in_tready, out_tvalid && !out_tready)
  // Reset empties the output register.
  `ASSERT_AFTER(a_reset_clears_output, !rst_n, !out_tvalid)

endmodule
